/* design/mwm_pkg.sv */
// ----------------------------------------------------------------------------
// mwm_pkg: shared types and helpers of the maze wall map
// Grid and log sizes, request and result structs, and the edge locator.
// ----------------------------------------------------------------------------
package mwm_pkg;

  localparam int GRID_SIZE = 32;
  localparam int LOG_DEPTH = 256;

  localparam int ROW_W     = (GRID_SIZE - 1 > 1) ? $clog2(GRID_SIZE - 1) : 1;
  localparam int BIT_W     = $clog2(GRID_SIZE);
  localparam int MAP_AW    = ROW_W + 1;
  localparam int MAP_DEPTH = 2 ** MAP_AW;
  localparam int MAP_W     = 2 * GRID_SIZE;
  localparam int LOG_AW    = $clog2(LOG_DEPTH);
  localparam int LOG_CW    = $clog2(LOG_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_UNDO   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SIDE_EAST  = 2'd0,
    SIDE_NORTH = 2'd1,
    SIDE_WEST  = 2'd2,
    SIDE_SOUTH = 2'd3
  } side_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY_RD,
    ST_QRY_ACC,
    ST_UNDO_CHK,
    ST_UNDO_LRD,
    ST_UNDO_MRD,
    ST_UNDO_MWR,
    ST_CLR_E,
    ST_CLR_N,
    ST_DONE
  } state_e;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [BIT_W-1:0] bit_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [1:0] side;
    logic       wall_seen;
    logic       log_enable;
    logic [8:0] undo_count;
    logic       start_walls;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       log_overflow;
    logic [3:0] walls_around;
    logic [3:0] known_around;
    logic [3:0] open_around;
    logic [2:0] wall_total;
    logic [2:0] unknown_total;
    logic [8:0] log_level;
  } result_t;

  typedef struct packed {
    logic on_board;
    logic plane;
    row_t row;
    bit_t bit_idx;
  } edge_t;

  typedef struct packed {
    item_t item;
    edge_t edge_loc;
  } cmd_t;

  typedef struct packed {
    logic [4:0] x;
    logic [4:0] y;
    logic [1:0] side;
  } log_t;

  function automatic edge_t locate(logic [4:0] x, logic [4:0] y, logic [1:0] side);
    edge_t e;
    int    xi;
    int    yi;
    e  = '0;
    xi = int'(x);
    yi = int'(y);
    case (side)
      SIDE_EAST: begin
        if (xi + 2 <= GRID_SIZE && yi < GRID_SIZE) begin
          e.on_board = 1'b1;
          e.row      = row_t'(x);
          e.bit_idx  = bit_t'(y);
        end
      end
      SIDE_NORTH: begin
        if (xi < GRID_SIZE && yi + 2 <= GRID_SIZE) begin
          e.on_board = 1'b1;
          e.plane    = 1'b1;
          e.row      = row_t'(y);
          e.bit_idx  = bit_t'(x);
        end
      end
      SIDE_WEST: begin
        if (xi >= 1 && xi <= GRID_SIZE - 1 && yi < GRID_SIZE) begin
          e.on_board = 1'b1;
          e.row      = row_t'(x - 5'd1);
          e.bit_idx  = bit_t'(y);
        end
      end
      default: begin
        if (yi >= 1 && yi <= GRID_SIZE - 1 && xi < GRID_SIZE) begin
          e.on_board = 1'b1;
          e.plane    = 1'b1;
          e.row      = row_t'(y - 5'd1);
          e.bit_idx  = bit_t'(x);
        end
      end
    endcase
    return e;
  endfunction

endpackage

/* design/mwm_ram.sv */
// ----------------------------------------------------------------------------
// mwm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mwm_front.sv */
// ----------------------------------------------------------------------------
// mwm_front: request intake
// Locates the addressed edge of each request and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module mwm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  mwm_pkg::item_t    item_i,
  output logic              cmd_valid_o,
  output mwm_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);

  mwm_pkg::cmd_t slot_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;
  mwm_pkg::cmd_t new_cmd;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    new_cmd.item     = item_i;
    new_cmd.edge_loc = mwm_pkg::locate(item_i.cell_x, item_i.cell_y, item_i.side);
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/mwm_out.sv */
// ----------------------------------------------------------------------------
// mwm_out: result queue
// Two-entry queue that holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module mwm_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_push_i,
  input  mwm_pkg::result_t res_i,
  output logic             res_full_o,
  output logic             empty,
  input  logic             pop,
  output mwm_pkg::result_t result_o
);

  mwm_pkg::result_t slot_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign result_o   = slot_q[rd_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_i |-> !res_full_o)
    else $error("result pushed into a full queue");

endmodule

/* design/mwm_back.sv */
// ----------------------------------------------------------------------------
// mwm_back: request execution
// Sequencer that owns the edge map, its row valid bits and the undo log.
// ----------------------------------------------------------------------------
module mwm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  mwm_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output mwm_pkg::result_t res_o
);

  mwm_pkg::state_e state_q, state_d;
  mwm_pkg::cmd_t   cur_q, cur_d;
  mwm_pkg::edge_t  edge_q, edge_d;
  logic [1:0]      side_q, side_d;
  logic [8:0]      cnt_q, cnt_d;
  logic [mwm_pkg::LOG_CW-1:0] top_q, top_d, top_dec;
  logic [mwm_pkg::MAP_DEPTH-1:0] valid_q, valid_d;
  logic            rvalid_q;
  logic            acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic [3:0]      walls_q, walls_d;
  logic [3:0]      known_q, known_d;

  logic                        map_we;
  logic [mwm_pkg::MAP_AW-1:0]  map_waddr, map_raddr;
  logic [mwm_pkg::MAP_W-1:0]   map_wdata, map_rdata;
  logic                        log_we;
  logic [mwm_pkg::LOG_AW-1:0]  log_waddr, log_raddr;
  mwm_pkg::log_t               log_wdata, log_rdata;

  logic [mwm_pkg::GRID_SIZE-1:0] row_walls, row_known, new_walls, new_known;
  logic            cur_wall, cur_known;
  mwm_pkg::edge_t  qry_edge;
  logic            clear_all;

  mwm_ram #(.WIDTH(mwm_pkg::MAP_W), .DEPTH(mwm_pkg::MAP_DEPTH)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  mwm_ram #(.WIDTH($bits(mwm_pkg::log_t)), .DEPTH(mwm_pkg::LOG_DEPTH)) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (log_we),
    .waddr_i (log_waddr),
    .wdata_i (log_wdata),
    .raddr_i (log_raddr),
    .rdata_o (log_rdata)
  );

  assign row_walls = rvalid_q ? map_rdata[mwm_pkg::GRID_SIZE-1:0] : '0;
  assign row_known = rvalid_q ? map_rdata[2*mwm_pkg::GRID_SIZE-1:mwm_pkg::GRID_SIZE] : '0;
  assign cur_wall  = row_walls[edge_q.bit_idx];
  assign cur_known = row_known[edge_q.bit_idx];
  assign top_dec   = top_q - mwm_pkg::LOG_CW'(1);
  assign qry_edge  = mwm_pkg::locate(cur_q.item.cell_x, cur_q.item.cell_y, side_q);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    edge_d    = edge_q;
    side_d    = side_q;
    cnt_d     = cnt_q;
    top_d     = top_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    walls_d   = walls_q;
    known_d   = known_q;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    map_we    = 1'b0;
    map_waddr = {edge_q.plane, edge_q.row};
    map_raddr = {edge_q.plane, edge_q.row};
    new_walls = row_walls;
    new_known = row_known;
    log_we    = 1'b0;
    log_waddr = top_q[mwm_pkg::LOG_AW-1:0];
    log_wdata = '{x: cur_q.item.cell_x, y: cur_q.item.cell_y, side: cur_q.item.side};
    log_raddr = top_dec[mwm_pkg::LOG_AW-1:0];
    clear_all = 1'b0;

    case (state_q)
      mwm_pkg::ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          edge_d    = cmd_i.edge_loc;
          side_d    = 2'd0;
          cnt_d     = cmd_i.item.undo_count;
          acc_d     = 1'b0;
          ovf_d     = 1'b0;
          walls_d   = 4'd0;
          known_d   = 4'd0;
          case (cmd_i.item.opcode)
            mwm_pkg::OP_UPDATE: state_d = mwm_pkg::ST_UPD_RD;
            mwm_pkg::OP_QUERY:  state_d = mwm_pkg::ST_QRY_RD;
            mwm_pkg::OP_UNDO:   state_d = mwm_pkg::ST_UNDO_CHK;
            default:            state_d = mwm_pkg::ST_CLR_E;
          endcase
        end
      end
      mwm_pkg::ST_UPD_RD: begin
        if (cur_q.item.log_enable) begin
          if (top_q < mwm_pkg::LOG_CW'(mwm_pkg::LOG_DEPTH)) begin
            log_we = 1'b1;
            top_d  = top_q + mwm_pkg::LOG_CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        state_d = mwm_pkg::ST_UPD_WR;
      end
      mwm_pkg::ST_UPD_WR: begin
        if (!edge_q.on_board) begin
          acc_d = cur_q.item.wall_seen;
        end else if (cur_known) begin
          if (cur_wall != cur_q.item.wall_seen) begin
            acc_d = 1'b0;
            new_walls[edge_q.bit_idx] = 1'b0;
            new_known[edge_q.bit_idx] = 1'b0;
            map_we = 1'b1;
          end else begin
            acc_d = 1'b1;
          end
        end else begin
          acc_d = 1'b1;
          new_walls[edge_q.bit_idx] = cur_q.item.wall_seen;
          new_known[edge_q.bit_idx] = 1'b1;
          map_we = 1'b1;
        end
        state_d = mwm_pkg::ST_DONE;
      end
      mwm_pkg::ST_QRY_RD: begin
        edge_d    = qry_edge;
        map_raddr = {qry_edge.plane, qry_edge.row};
        state_d   = mwm_pkg::ST_QRY_ACC;
      end
      mwm_pkg::ST_QRY_ACC: begin
        walls_d[side_q] = edge_q.on_board ? cur_wall : 1'b1;
        known_d[side_q] = edge_q.on_board ? cur_known : 1'b1;
        side_d = side_q + 2'd1;
        state_d = (side_q == 2'd3) ? mwm_pkg::ST_DONE : mwm_pkg::ST_QRY_RD;
      end
      mwm_pkg::ST_UNDO_CHK: begin
        if (cnt_q == 9'd0 || top_q == '0) begin
          state_d = mwm_pkg::ST_DONE;
        end else begin
          top_d   = top_dec;
          cnt_d   = cnt_q - 9'd1;
          state_d = mwm_pkg::ST_UNDO_LRD;
        end
      end
      mwm_pkg::ST_UNDO_LRD: begin
        edge_d  = mwm_pkg::locate(log_rdata.x, log_rdata.y, log_rdata.side);
        state_d = mwm_pkg::ST_UNDO_MRD;
      end
      mwm_pkg::ST_UNDO_MRD: begin
        state_d = mwm_pkg::ST_UNDO_MWR;
      end
      mwm_pkg::ST_UNDO_MWR: begin
        if (edge_q.on_board) begin
          new_walls[edge_q.bit_idx] = 1'b0;
          new_known[edge_q.bit_idx] = 1'b0;
          map_we = 1'b1;
        end
        state_d = mwm_pkg::ST_UNDO_CHK;
      end
      mwm_pkg::ST_CLR_E: begin
        clear_all = 1'b1;
        top_d     = '0;
        if (cur_q.item.start_walls) begin
          map_we       = 1'b1;
          map_waddr    = {1'b0, mwm_pkg::row_t'(0)};
          new_walls    = '0;
          new_walls[0] = 1'b1;
          new_known    = '0;
          new_known[0] = 1'b1;
          state_d      = mwm_pkg::ST_CLR_N;
        end else begin
          state_d = mwm_pkg::ST_DONE;
        end
      end
      mwm_pkg::ST_CLR_N: begin
        map_we       = 1'b1;
        map_waddr    = {1'b1, mwm_pkg::row_t'(0)};
        new_walls    = '0;
        new_known    = '0;
        new_known[0] = 1'b1;
        state_d      = mwm_pkg::ST_DONE;
      end
      mwm_pkg::ST_DONE: begin
        res_push_o = 1'b1;
        state_d    = mwm_pkg::ST_IDLE;
      end
      default: begin
        state_d = mwm_pkg::ST_IDLE;
      end
    endcase

    map_wdata = {new_known, new_walls};
    valid_d   = clear_all ? '0 : valid_q;
    if (map_we) begin
      valid_d[map_waddr] = 1'b1;
    end
  end

  always_comb begin
    res_o.accepted      = acc_q;
    res_o.log_overflow  = ovf_q;
    res_o.walls_around  = walls_q;
    res_o.known_around  = known_q;
    res_o.open_around   = known_q & ~walls_q;
    res_o.wall_total    = 3'(walls_q[0]) + 3'(walls_q[1]) + 3'(walls_q[2]) + 3'(walls_q[3]);
    res_o.unknown_total = (cur_q.item.opcode == mwm_pkg::OP_QUERY)
                        ? 3'(!known_q[0]) + 3'(!known_q[1]) + 3'(!known_q[2])
                          + 3'(!known_q[3])
                        : 3'd0;
    res_o.log_level     = 9'(top_q);
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    edge_q  <= edge_d;
    side_q  <= side_d;
    cnt_q   <= cnt_d;
    acc_q   <= acc_d;
    ovf_q   <= ovf_d;
    walls_q <= walls_d;
    known_q <= known_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mwm_pkg::ST_IDLE;
      top_q    <= '0;
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      valid_q  <= valid_d;
      rvalid_q <= valid_q[map_raddr];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= mwm_pkg::LOG_CW'(mwm_pkg::LOG_DEPTH))
    else $error("undo log level beyond its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mwm_pkg::ST_DONE |=> state_q == mwm_pkg::ST_IDLE)
    else $error("sequencer did not return to idle after a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_we |-> (state_q == mwm_pkg::ST_UPD_WR || state_q == mwm_pkg::ST_UNDO_MWR
             || state_q == mwm_pkg::ST_CLR_E || state_q == mwm_pkg::ST_CLR_N))
    else $error("map written outside a write step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == mwm_pkg::ST_IDLE && !res_full_i))
    else $error("request taken while busy or with no room for its result");

endmodule

/* design/maze_wall_map.sv */
// ----------------------------------------------------------------------------
// maze_wall_map: wall and known-bit map of a square maze with an undo log
// Top level joining the request queue, the sequencer and the result queue.
// ----------------------------------------------------------------------------
// Requests are worked one at a time by a sequencer over a single-port-read
// row memory of the map. An update reads the edge's row and then writes it,
// a query reads the rows of the four sides in turn, a clear may write two
// start rows, and an undo pops its entries one by one, since each entry needs
// a log read and a map read-modify-write. Clearing the map is immediate through
// per-row valid bits. Two requests and two results can wait in the queues.
module maze_wall_map (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  mwm_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output mwm_pkg::result_t result_o
);

  logic             cmd_valid;
  logic             cmd_pop;
  mwm_pkg::cmd_t    cmd;
  logic             res_full;
  logic             res_push;
  mwm_pkg::result_t res;

  mwm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  mwm_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

endmodule
